@@ hdl/hhsr_pkg.sv @@
// Shared constants, types and table function of the sodium gate rate unit.
package hhsr_pkg;

    // Selector codes
    typedef enum logic [1:0] {
        OP_ALPHA_M = 2'd0,
        OP_BETA_M  = 2'd1,
        OP_ALPHA_H = 2'd2,
        OP_BETA_H  = 2'd3
    } t_op;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_M_SCALE = 1'b0,
        REG_H_SCALE = 1'b1
    } t_cfg_reg;

    localparam int EXP_ADDR_BITS_DEF = 8;

    localparam logic [32:0] LOG2E_Q32   = 33'd6196328019;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;
    localparam logic [63:0] ONE_Q32     = 64'h1_0000_0000;
    localparam logic [61:0] SING_Q32    = 62'd42950;
    localparam logic [15:0] SCALE_RESET = 16'd4096;

    // Reciprocals for the exponent divide, floor(2^32/div)
    localparam logic [31:0] RECIP_10 = 32'(64'h1_0000_0000 / 10);
    localparam logic [31:0] RECIP_18 = 32'(64'h1_0000_0000 / 18);
    localparam logic [31:0] RECIP_20 = 32'(64'h1_0000_0000 / 20);

    // Datapath widths
    localparam int Q_W    = 33;   // divider quotient bits
    localparam int REM_W  = 64;   // numerator and remainder
    localparam int DEN_W  = 62;   // divisor
    localparam int BASE_W = 58;   // base rate in Q16
    localparam int PRE_DIV_STAGES = 8;
    localparam int LATENCY = PRE_DIV_STAGES + Q_W + 2;

    // Voltage offset in 1/256 mV
    function automatic logic signed [16:0] off_of(input t_op op);
        logic signed [16:0] off;
        case (op)
            OP_ALPHA_M: off = 17'sd10240;
            OP_BETA_M:  off = 17'sd16640;
            OP_ALPHA_H: off = 17'sd16640;
            OP_BETA_H:  off = 17'sd8960;
            default:    off = 17'sd0;
        endcase
        return off;
    endfunction

    // Exponent divisor in mV
    function automatic logic [4:0] div_of(input t_op op);
        logic [4:0] dv;
        case (op)
            OP_ALPHA_M: dv = 5'd10;
            OP_BETA_M:  dv = 5'd18;
            OP_ALPHA_H: dv = 5'd20;
            OP_BETA_H:  dv = 5'd10;
            default:    dv = 5'd10;
        endcase
        return dv;
    endfunction

    function automatic logic [31:0] recip_of(input t_op op);
        logic [31:0] rc;
        case (op)
            OP_ALPHA_M: rc = RECIP_10;
            OP_BETA_M:  rc = RECIP_18;
            OP_ALPHA_H: rc = RECIP_20;
            OP_BETA_H:  rc = RECIP_10;
            default:    rc = RECIP_10;
        endcase
        return rc;
    endfunction

    // 2^(k/2^b) in Q30 from the integer series of e^x
    function automatic logic [31:0] pow2_entry(input int unsigned k, input int unsigned b);
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] term;
        logic        stop;
        x    = (64'(k) * 64'(LN2_Q30)) >> b;
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        stop = 1'b0;
        for (int i = 1; i <= 24; i++) begin
            if (!stop) begin
                term = ((term * x) >> 30) / 64'(i);
                if (term == 64'd0) begin
                    stop = 1'b1;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return sum[31:0];
    endfunction

endpackage

@@ hdl/hh_sodium_rate_functions_unit.sv @@
// Sodium gate rate unit: pipelined exponent, table exp2, divider and scaling.
// Pipeline: 8 front stages, 33 divider stages one quotient bit each, scale multiply and
// output register; each item passes through all of them before its result strobe.
// Throughput: one item per cycle; busy is high only while reset is asserted.
// Results are strobed for one cycle and cannot be held off by the receiver.
// Synchronous active-low reset clears all valid bits and sets both scales to 1.0.
module hh_sodium_rate_functions_unit
    import hhsr_pkg::*;
#(
    parameter int EXP_TABLE_ADDR_BITS = EXP_ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_voltage,
    output logic        o_valid,
    output logic [31:0] o_rate,
    output logic        o_saturated,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int B     = EXP_TABLE_ADDR_BITS;
    localparam int LOW   = 16 - B;
    localparam int TAB_N = (1 << B) + 1;
    localparam int CMP_W = DEN_W + Q_W;

    logic w_accept;
    assign busy        = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign w_accept    = start & ~busy;

    // Configuration registers
    logic [15:0] r_m_scale, r_h_scale;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_scale <= SCALE_RESET;
            r_h_scale <= SCALE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_M_SCALE: r_m_scale <= i_cfg_data;
                REG_H_SCALE: r_h_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: offset voltage, magnitude and sign
    t_op               w_op;
    logic signed [16:0] w_d;
    logic [15:0]        w_mag;
    assign w_op  = t_op'(i_op);
    assign w_d   = 17'(signed'(i_voltage)) + off_of(w_op);
    assign w_mag = w_d[16] ? 16'(-w_d) : w_d[15:0];

    t_op         r1_op;
    logic [15:0] r1_mag;
    logic        r1_dpos;
    always_ff @(posedge i_clk) begin
        r1_op   <= w_op;
        r1_mag  <= w_mag;
        r1_dpos <= ~w_d[16] && (w_d != 17'sd0);
    end

    // Stage 2: |d|*log2(e), pre-rounded
    logic [48:0] w_lp;
    assign w_lp = 49'(r1_mag) * 49'(LOG2E_Q32);

    t_op         r2_op;
    logic [15:0] r2_mag;
    logic        r2_dpos;
    logic [25:0] r2_p;
    always_ff @(posedge i_clk) begin
        r2_op   <= r1_op;
        r2_mag  <= r1_mag;
        r2_dpos <= r1_dpos;
        r2_p    <= 26'(w_lp[48:24]) + 26'(div_of(r1_op) >> 1);
    end

    // Stage 3: quotient estimate by reciprocal
    logic [57:0] w_qp;
    assign w_qp = 58'(r2_p) * 58'(recip_of(r2_op));

    t_op         r3_op;
    logic [15:0] r3_mag;
    logic        r3_dpos;
    logic [25:0] r3_p;
    logic [20:0] r3_qe;
    always_ff @(posedge i_clk) begin
        r3_op   <= r2_op;
        r3_mag  <= r2_mag;
        r3_dpos <= r2_dpos;
        r3_p    <= r2_p;
        r3_qe   <= w_qp[52:32];
    end

    // Stage 4: correct the estimate, apply sign
    logic [25:0] w_rq;
    logic [21:0] w_q;
    assign w_rq = r3_p - (26'(r3_qe) * 26'(div_of(r3_op)));
    assign w_q  = 22'(r3_qe) + 22'(w_rq >= 26'(div_of(r3_op)));

    t_op                r4_op;
    logic [15:0]        r4_mag;
    logic signed [22:0] r4_t;
    always_ff @(posedge i_clk) begin
        r4_op  <= r3_op;
        r4_mag <= r3_mag;
        r4_t   <= r3_dpos ? -signed'({1'b0, w_q}) : signed'({1'b0, w_q});
    end

    // Stage 5: exp2 table read, two neighbors
    logic [31:0] w_tab [TAB_N];
    for (genvar g = 0; g < TAB_N; g++) begin : g_tab
        assign w_tab[g] = pow2_entry(g, B);
    end

    logic [B:0] w_idx0, w_idx1;
    assign w_idx0 = {1'b0, r4_t[15 -: B]};
    assign w_idx1 = w_idx0 + 1'b1;

    t_op               r5_op;
    logic [15:0]       r5_mag;
    logic signed [6:0] r5_n;
    logic [LOW-1:0]    r5_rem;
    logic [31:0]       r5_lo, r5_hi;
    always_ff @(posedge i_clk) begin
        r5_op  <= r4_op;
        r5_mag <= r4_mag;
        r5_n   <= r4_t[22:16];
        r5_rem <= r4_t[LOW-1:0];
        r5_lo  <= w_tab[w_idx0];
        r5_hi  <= w_tab[w_idx1];
    end

    // Stage 6: linear interpolation of the mantissa
    logic [31:0]     w_diff;
    logic [32+LOW:0] w_ip;
    assign w_diff = (r5_hi > r5_lo) ? r5_hi - r5_lo : 32'd0;
    assign w_ip   = (33'(w_diff) * (32+LOW+1)'(r5_rem))
                    + ((32+LOW+1)'(1) << (LOW - 1));

    t_op               r6_op;
    logic [15:0]       r6_mag;
    logic signed [6:0] r6_n;
    logic [31:0]       r6_mant;
    always_ff @(posedge i_clk) begin
        r6_op   <= r5_op;
        r6_mag  <= r5_mag;
        r6_n    <= r5_n;
        r6_mant <= r5_lo + 32'(w_ip >> LOW);
    end

    // Stage 7: scale mantissa by 2^(n+2), round right shifts
    logic signed [7:0] w_sh;
    logic [5:0]        w_sr;
    logic [63:0]       w_e;
    assign w_sh = 8'(r6_n) + 8'sd2;
    assign w_sr = 6'(-w_sh);
    always_comb begin
        if (!w_sh[7]) begin
            w_e = 64'(r6_mant) << w_sh[5:0];
        end else begin
            w_e = (64'(r6_mant) + (64'd1 << (w_sr - 6'd1))) >> w_sr;
        end
    end

    t_op         r7_op;
    logic [15:0] r7_mag;
    logic [63:0] r7_e;
    always_ff @(posedge i_clk) begin
        r7_op  <= r6_op;
        r7_mag <= r6_mag;
        r7_e   <= w_e;
    end

    // Stage 8: form numerator and divisor, or the direct base rate
    logic [61:0] w_ax, w_den3;
    logic        w_sing;
    logic [11:0] w_k;
    logic [73:0] w_dprod;
    logic [63:0] w_num0, w_num3;
    logic [REM_W-1:0] w_rem0;
    logic [DEN_W-1:0] w_den0;
    logic             w_use0;

    assign w_ax    = (r7_e >= ONE_Q32) ? 62'(r7_e - ONE_Q32) : 62'(ONE_Q32 - r7_e);
    assign w_sing  = w_ax <= SING_Q32;
    assign w_k     = (r7_op == OP_BETA_M) ? 12'd4000 : 12'd70;
    assign w_dprod = 74'(r7_e[61:0]) * 74'(w_k) + 74'(1 << 15);
    assign w_num0  = (64'(21'(r7_mag) * 21'd25) << 42) + 64'(w_ax >> 1);
    assign w_den3  = 62'(r7_e) + 62'(ONE_Q32);
    assign w_num3  = (64'd1000 << 48) + 64'(w_den3 >> 1);

    always_comb begin
        w_rem0 = 64'(w_dprod >> 16);
        w_den0 = '1;
        w_use0 = 1'b0;
        case (r7_op)
            OP_ALPHA_M: begin
                if (w_sing) begin
                    w_rem0 = 64'd1000 << 16;
                end else begin
                    w_rem0 = w_num0;
                    w_den0 = w_ax;
                    w_use0 = 1'b1;
                end
            end
            OP_BETA_M, OP_ALPHA_H: ;
            OP_BETA_H: begin
                w_rem0 = w_num3;
                w_den0 = w_den3;
                w_use0 = 1'b1;
            end
            default: ;
        endcase
    end

    // Divider pipeline: one quotient bit per stage, bypass items never subtract
    logic [REM_W-1:0] r_dv_rem [Q_W+1];
    logic [DEN_W-1:0] r_dv_den [Q_W+1];
    logic [Q_W-1:0]   r_dv_q   [Q_W+1];
    logic             r_dv_use [Q_W+1];
    logic             r_dv_h   [Q_W+1];

    always_ff @(posedge i_clk) begin
        r_dv_rem[0] <= w_rem0;
        r_dv_den[0] <= w_den0;
        r_dv_q[0]   <= '0;
        r_dv_use[0] <= w_use0;
        r_dv_h[0]   <= r7_op[1];
    end

    for (genvar s = 0; s < Q_W; s++) begin : g_div
        localparam int J = Q_W - 1 - s;
        logic [CMP_W-1:0] w_sub;
        logic [CMP_W-1:0] w_rx;
        logic             w_take;
        assign w_sub  = CMP_W'(r_dv_den[s]) << J;
        assign w_rx   = CMP_W'(r_dv_rem[s]);
        assign w_take = w_rx >= w_sub;
        always_ff @(posedge i_clk) begin
            r_dv_rem[s+1] <= w_take ? REM_W'(w_rx - w_sub) : r_dv_rem[s];
            r_dv_den[s+1] <= r_dv_den[s];
            r_dv_q[s+1]   <= r_dv_q[s] | (Q_W'(w_take) << J);
            r_dv_use[s+1] <= r_dv_use[s];
            r_dv_h[s+1]   <= r_dv_h[s];
        end
    end

    // Scale multiply
    logic [BASE_W-1:0] w_base;
    logic [15:0]       w_scale;
    assign w_base  = r_dv_use[Q_W] ? BASE_W'(r_dv_q[Q_W]) : r_dv_rem[Q_W][BASE_W-1:0];
    assign w_scale = r_dv_h[Q_W] ? r_h_scale : r_m_scale;

    logic [BASE_W+15:0] r_prod;
    always_ff @(posedge i_clk) begin
        r_prod <= (BASE_W+16)'(w_base) * (BASE_W+16)'(w_scale);
    end

    // Round, clamp and drive the result
    logic [BASE_W+16:0] w_rnd;
    assign w_rnd = (BASE_W+17)'(r_prod) + (BASE_W+17)'(1 << 19);

    logic [31:0] r_rate;
    logic        r_sat;
    always_ff @(posedge i_clk) begin
        r_sat  <= |w_rnd[BASE_W+16:52];
        r_rate <= (|w_rnd[BASE_W+16:52]) ? '1 : w_rnd[51:20];
    end

    // Advance valid bits
    logic [LATENCY-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], w_accept};
        end
    end

    assign o_valid     = r_vld[LATENCY-1];
    assign o_rate      = r_rate;
    assign o_saturated = r_sat;

    // Checks
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_valid)
        else $error("result strobe missing after accepted item");

    a_sat_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_rate == 32'hFFFF_FFFF))
        else $error("saturated result not clamped");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[PRE_DIV_STAGES+Q_W-1] && r_dv_use[Q_W])
            |-> (r_dv_rem[Q_W] < REM_W'(r_dv_den[Q_W])))
        else $error("divider remainder not below divisor");

endmodule
